### hdl/lcs_pkg.sv
// Shared constants, types and helper functions of the LCS length block.
package lcs_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int VAL_W   = CNT_W;
  localparam int SYM_W   = 8;
  localparam int LEN_W   = 7;
  localparam int LEN_MAX = (1 << LEN_W) - 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic match;
    val_t diag;
    val_t up;
    val_t left;
  } cell_in_t;

  function automatic len_t sat_len(val_t v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(w);
  endfunction

endpackage

### hdl/lcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lcs_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/lcs_cell.sv
// One DP cell update: diagonal plus one on a match, else the larger neighbor.
module lcs_cell (
  input  lcs_pkg::cell_in_t cin,
  output lcs_pkg::val_t     cell_val
);
  import lcs_pkg::*;

  always_comb begin
    if (cin.match) begin
      cell_val = cin.diag + VAL_W'(1);
    end else if (cin.up > cin.left) begin
      cell_val = cin.up;
    end else begin
      cell_val = cin.left;
    end
  end

endmodule

### hdl/lcs_length_dp.sv
// Top level of the LCS length block: control, row sweep and result register.
// A mode 0 item is taken in idle and does not leave it. A mode 1 item that
// updates the row sweeps it, one cell per cycle through the row memory port.
// A last first-string item then reads the final cell in ST_RDRES, and the
// result waits in an output register while the next item is taken.
// Reset clears the control state and the row valid bits at once; no sweep.
module lcs_length_dp (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic       s_tuser,   // [0] mode
  input  logic       s_tlast,   // last_symbol
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [6:0] lcs_length, [7] zero
);
  import lcs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_RDRES = 4'b0100,
    ST_RES   = 4'b1000
  } state_t;

  state_t state;
  cnt_t   second_length;
  cnt_t   first_count;
  logic   closed;
  logic [MAX_LEN-1:0] row_valid;
  logic   row_valid_q;
  cnt_t   iss;
  logic   pv;
  cnt_t   pj;
  val_t   diag;
  val_t   left;
  sym_t   sym_q;
  logic   last_q;
  len_t   out_len;

  logic     accept;
  logic     sweep_go;
  cnt_t     eff_len;
  cnt_t     lim;
  logic     rd_en;
  idx_t     rd_addr;
  logic     str_we;
  logic     row_we;
  idx_t     row_waddr;
  sym_t     str_rdata;
  val_t     row_rdata;
  cell_in_t cin;
  val_t     cell_val;
  val_t     res_val;
  logic     out_free;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign sweep_go = (first_count < CNT_W'(MAX_LEN)) && (second_length != '0);
  assign eff_len  = closed ? '0 : second_length;
  assign lim      = second_length - CNT_W'(1);
  assign row_waddr = pj[IDX_W-1:0];
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {1'b0, out_len};

  assign cin.match = (str_rdata == sym_q);
  assign cin.diag  = diag;
  assign cin.up    = row_valid_q ? row_rdata : '0;
  assign cin.left  = left;
  assign res_val   = ((second_length != '0) && row_valid_q) ? row_rdata : '0;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    str_we  = 1'b0;
    row_we  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && s_tuser && sweep_go) begin
          rd_en = 1'b1;
        end
        if (accept && !s_tuser && (eff_len < CNT_W'(MAX_LEN))) begin
          str_we = 1'b1;
        end
      end
      ST_SWEEP: begin
        row_we = pv;
        if (iss < second_length) begin
          rd_en   = 1'b1;
          rd_addr = iss[IDX_W-1:0];
        end
      end
      ST_RDRES: begin
        rd_en   = 1'b1;
        rd_addr = lim[IDX_W-1:0];
      end
      ST_RES: begin
      end
      default: begin
      end
    endcase
  end

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN), .ADDR_W(IDX_W)) u_str_ram (
    .clk     (clk),
    .wr_en   (str_we),
    .wr_addr (eff_len[IDX_W-1:0]),
    .wr_data (s_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (str_rdata)
  );

  lcs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN), .ADDR_W(IDX_W)) u_row_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (row_waddr),
    .wr_data (cell_val),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (row_rdata)
  );

  lcs_cell u_cell (
    .cin      (cin),
    .cell_val (cell_val)
  );

  always_ff @(posedge clk) begin
    if (rd_en) begin
      row_valid_q <= row_valid[rd_addr];
    end
    if (rst) begin
      state         <= ST_IDLE;
      second_length <= '0;
      first_count   <= '0;
      closed        <= 1'b0;
      row_valid     <= '0;
      pv            <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_RES)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && !s_tuser) begin
            second_length <= (eff_len < CNT_W'(MAX_LEN)) ? eff_len + CNT_W'(1) : eff_len;
            if (closed || s_tlast) begin
              row_valid   <= '0;
              first_count <= '0;
            end
            closed <= s_tlast;
          end else if (accept) begin
            sym_q  <= s_tdata;
            last_q <= s_tlast;
            if (first_count < CNT_W'(MAX_LEN)) begin
              first_count <= first_count + CNT_W'(1);
            end
            if (sweep_go) begin
              iss   <= CNT_W'(1);
              pv    <= 1'b1;
              pj    <= '0;
              diag  <= '0;
              left  <= '0;
              state <= ST_SWEEP;
            end else if (s_tlast) begin
              state <= ST_RDRES;
            end
          end
        end
        ST_SWEEP: begin
          if (pv) begin
            row_valid[row_waddr] <= 1'b1;
            diag <= cin.up;
            left <= cell_val;
          end
          if (iss < second_length) begin
            pv  <= 1'b1;
            pj  <= iss;
            iss <= iss + CNT_W'(1);
          end else begin
            pv <= 1'b0;
            if (!pv) begin
              state <= last_q ? ST_RDRES : ST_IDLE;
            end
          end
        end
        ST_RDRES: begin
          state <= ST_RES;
        end
        ST_RES: begin
          if (out_free) begin
            out_len     <= sat_len(res_val);
            m_tvalid    <= 1'b1;
            row_valid   <= '0;
            first_count <= '0;
            closed      <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/lcs_length_dp_checker.sv
// Port-level assertions for the LCS length block and the bind that attaches them.
module lcs_length_dp_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tuser,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import lcs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result item changed or vanished.");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata <= 8'(MAX_LEN)))
    else $error("Result length exceeds the string capacity.");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> s_tready)
    else $error("Second-string item did not complete in one cycle.");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser && s_tlast |=> !s_tready)
    else $error("Input taken before the final result was formed.");

endmodule

bind lcs_length_dp lcs_length_dp_checker u_lcs_chk (.*);
